@@ src/sto_pkg.sv @@
// Shepard-tone oscillator package: sizes, the cell word type, cosine and log2 tables.
`default_nettype none
package sto_pkg;

   localparam int MAX_OCTAVES    = 32;
   localparam int COS_TABLE_BITS = 10;

   localparam int QN  = 1 << (COS_TABLE_BITS - 2);
   localparam int LN  = 1 << COS_TABLE_BITS;
   localparam int XW  = 42;
   localparam int SW  = 40;
   localparam int FW  = 22;
   localparam int LW  = 22;

   localparam logic [31:0]          FREQ_LIMIT = 32'd2621440;
   localparam logic signed [XW-1:0] X_ONE      = XW'(64'h1_0000_0000);

   typedef struct packed {
      logic                 valid;
      logic                 live;
      logic signed [XW-1:0] x;
      logic signed [17:0]   y;
      logic signed [SW-1:0] sum;
   } cell_data_type;

   typedef logic [16:0] qcos_tab_type [0:QN];
   typedef logic [15:0] log_tab_type [0:LN-1];

   function automatic logic [16:0] quarter_cos(input logic [63:0] a);
      logic [63:0] th, z, t1, t2, t3, t4, h, r, q;
      th = (a * 64'd1686629713) >> 16;
      z  = (th * th) >> 30;
      t1 = 64'd1073741824 - z / 64'd90;
      t2 = 64'd1073741824 - ((z * t1) >> 30) / 64'd56;
      t3 = 64'd1073741824 - ((z * t2) >> 30) / 64'd30;
      t4 = 64'd1073741824 - ((z * t3) >> 30) / 64'd12;
      h  = ((z * t4) >> 30) / 64'd2;
      r  = (h >= 64'd1073741824) ? 64'd0 : (64'd1073741824 - h);
      q  = (r + 64'd8192) >> 14;
      if (q > 64'd65536) begin
         q = 64'd65536;
      end
      return q[16:0];
   endfunction

   function automatic qcos_tab_type qcos_init();
      qcos_tab_type t;
      for (int k = 0; k <= QN; k++) begin
         t[k] = quarter_cos(64'(k) << (16 - (COS_TABLE_BITS - 2)));
      end
      return t;
   endfunction

   function automatic log_tab_type log_init();
      log_tab_type t;
      logic [63:0] m;
      logic [15:0] fr;
      for (int k = 0; k < LN; k++) begin
         m  = 64'd1073741824 + (64'(k) << (30 - COS_TABLE_BITS));
         fr = '0;
         for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= 64'd2147483648) begin
               m = m >> 1;
               fr[i] = 1'b1;
            end
         end
         t[k] = fr;
      end
      return t;
   endfunction

   localparam qcos_tab_type QCOS    = qcos_init();
   localparam log_tab_type  LOG_TAB = log_init();

   // cosine of a turn, table index in, Q1.16 out
   function automatic logic signed [17:0] cos_turn(input logic [COS_TABLE_BITS-1:0] idx);
      logic [1:0]                  quad;
      logic [COS_TABLE_BITS-2:0]   j;
      logic [16:0]                 q;
      quad = idx[COS_TABLE_BITS-1 -: 2];
      if (quad[0]) begin
         j = (COS_TABLE_BITS-1)'(QN) - {1'b0, idx[COS_TABLE_BITS-3:0]};
      end else begin
         j = {1'b0, idx[COS_TABLE_BITS-3:0]};
      end
      q = QCOS[j];
      if (quad[1] ^ quad[0]) begin
         return -$signed({1'b0, q});
      end
      return $signed({1'b0, q});
   endfunction

endpackage
`default_nettype wire

@@ src/sto_if.sv @@
// Request and response channel interfaces.
`default_nettype none
interface sto_req_if;
   import sto_pkg::*;
   logic        valid;
   logic        ready;
   logic [31:0] freq;
   modport source (output valid, output freq, input ready);
   modport sink   (input valid, input freq, output ready);
endinterface

interface sto_rsp_if;
   import sto_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [FW-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

@@ src/sto_cell.sv @@
// One octave cell: weights and accumulates a partial, steps x and y to the next cell.
`default_nettype none
module sto_cell
   import sto_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [15:0]   inv_log2_nyquist,
   input  wire cell_data_type d_in,
   output cell_data_type      d_out
);

   cell_data_type        d_ff, d_in_nx;
   logic signed [17:0]   c;
   logic signed [18:0]   diff;
   logic [16:0]          w;
   logic signed [35:0]   term;
   logic signed [35:0]   ysq;
   logic signed [18:0]   yt;
   logic signed [XW-1:0] x_n;

   always_comb begin
      c    = cos_turn(d_in.x[31 -: COS_TABLE_BITS]);
      diff = 19'sd65536 - {c[17], c};
      w    = diff[17:1];
      term = $signed({1'b0, w}) * d_in.y;
      ysq  = d_in.y * d_in.y;
      yt   = $signed(ysq[33:15]) - 19'sd65536;
      x_n  = d_in.x + $signed(XW'({1'b0, inv_log2_nyquist, 16'h0}));

      d_in_nx.valid = d_in.valid;
      d_in_nx.live  = d_in.live && !(x_n > X_ONE);
      d_in_nx.x     = x_n;
      d_in_nx.y     = yt[17:0];
      d_in_nx.sum   = d_in.live ? d_in.sum + SW'(term) : d_in.sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.valid <= 1'b0;
      end else begin
         d_ff.valid <= d_in_nx.valid;
      end
      d_ff.live <= d_in_nx.live;
      d_ff.x    <= d_in_nx.x;
      d_ff.y    <= d_in_nx.y;
      d_ff.sum  <= d_in_nx.sum;
   end

   assign d_out = d_ff;

endmodule
`default_nettype wire

@@ src/sto_front.sv @@
// Front end: octave folding, phase accumulator, log2 position, carrier and launch.
`default_nettype none
module sto_front
   import sto_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   sto_req_if.sink          req_ch,
   input  wire logic [31:0] sample_period_scale,
   input  wire logic [15:0] inv_log2_nyquist,
   input  wire logic        out_free,
   input  wire logic        chain_done,
   output logic             zero_done,
   output cell_data_type    launch
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_HALVE = 6'b000010,
      S_MUL   = 6'b000100,
      S_LOG   = 6'b001000,
      S_XMUL  = 6'b010000,
      S_RUN   = 6'b100000
   } front_state_type;

   front_state_type      state_ff, state_in;
   logic [31:0]          f_ff, f_in;
   logic [31:0]          inc_ff;
   logic [31:0]          phase_ff, phase_in;
   logic signed [LW-1:0] log_ff;
   logic signed [XW-1:0] x_ff;
   logic signed [17:0]   y_ff;
   logic                 launch_ff, launch_in;
   logic                 zero_ff, zero_in;
   logic                 accept;
   logic [53:0]          prod;
   logic [4:0]           p;
   logic [21+COS_TABLE_BITS:0] wide;
   logic [COS_TABLE_BITS-1:0]  k;
   logic signed [LW-1:0] log_in;
   logic signed [38:0]   xprod;

   // a zero word still on its way to the output word holds off the next request
   assign req_ch.ready = (state_ff == S_IDLE) && out_free && !zero_ff;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      prod = f_ff[21:0] * sample_period_scale;
      p    = '0;
      for (int i = 0; i < 22; i++) begin
         if (f_ff[i]) begin
            p = 5'(i);
         end
      end
      wide   = {f_ff[21:0], {COS_TABLE_BITS{1'b0}}} >> p;
      k      = wide[COS_TABLE_BITS-1:0];
      log_in = {6'(p) - 6'd16, LOG_TAB[k]};
      xprod  = log_ff * $signed({1'b0, inv_log2_nyquist});
   end

   always_comb begin
      state_in  = state_ff;
      f_in      = f_ff;
      phase_in  = phase_ff;
      launch_in = 1'b0;
      zero_in   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               f_in = req_ch.freq;
               if (req_ch.freq == 32'd0) begin
                  zero_in = 1'b1;
               end else begin
                  state_in = S_HALVE;
               end
            end
         end
         S_HALVE: begin
            if (f_ff > FREQ_LIMIT) begin
               f_in = f_ff >> 1;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: state_in = S_LOG;
         S_LOG: begin
            phase_in = phase_ff + inc_ff;
            state_in = S_XMUL;
         end
         S_XMUL: begin
            launch_in = 1'b1;
            state_in  = S_RUN;
         end
         S_RUN: begin
            if (chain_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         phase_ff  <= '0;
         launch_ff <= 1'b0;
         zero_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         launch_ff <= launch_in;
         zero_ff   <= zero_in;
      end
      f_ff   <= f_in;
      inc_ff <= prod[47:16];
      if (state_ff == S_LOG) begin
         log_ff <= log_in;
      end
      if (state_ff == S_XMUL) begin
         x_ff <= XW'(xprod);
         y_ff <= cos_turn(phase_ff[31 -: COS_TABLE_BITS]);
      end
   end

   assign zero_done    = zero_ff;
   assign launch.valid = launch_ff;
   assign launch.live  = 1'b1;
   assign launch.x     = x_ff;
   assign launch.y     = y_ff;
   assign launch.sum   = '0;

endmodule
`default_nettype wire

@@ src/shepard_tone_oscillator_top.sv @@
// Shepard-tone oscillator top level: register port, front end, octave cell row, output word.
//
// One frequency word in, one sample word out. A nonzero frequency goes through octave folding
// (one halving a cycle until it is in range), the setup steps (phase multiply, phase add and
// log2, position multiply and carrier lookup), each of the 32 octave cells of the row and then
// the output word; a zero frequency is registered as a zero word and then goes into the output
// word. One word is in flight at a time, and a new request is taken once the output word is
// empty or being taken. Registers: 0x0 sample_period_scale, 0x4 inv_log2_nyquist; write them
// only while idle.
`default_nettype none
module shepard_tone_oscillator_top
   import sto_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   sto_req_if.sink          req_ch,
   sto_rsp_if.source        rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [31:0]          scale_ff;
   logic [15:0]          inv_ff;
   logic                 wr;
   logic                 out_valid_ff, out_valid_in;
   logic signed [FW-1:0] sample_ff, sample_in;
   logic                 out_free;
   logic                 zero_done;
   logic signed [SW-1:0] rnd;
   logic signed [SW-1:0] res;
   cell_data_type        chain [0:MAX_OCTAVES];

   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[2] ? {16'h0, inv_ff} : scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= 32'd89478;
         inv_ff   <= 16'd4504;
      end else if (wr) begin
         if (csr_paddr[2]) begin
            inv_ff <= csr_pwdata[15:0];
         end else begin
            scale_ff <= csr_pwdata;
         end
      end
   end

   assign out_free = !out_valid_ff || rsp_ch.ready;

   sto_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_ch              (req_ch),
      .sample_period_scale (scale_ff),
      .inv_log2_nyquist    (inv_ff),
      .out_free            (out_free),
      .chain_done          (chain[MAX_OCTAVES].valid),
      .zero_done           (zero_done),
      .launch              (chain[0])
   );

   for (genvar n = 0; n < MAX_OCTAVES; n++) begin : g_cell
      sto_cell u_cell (
         .clock            (clock),
         .reset            (reset),
         .inv_log2_nyquist (inv_ff),
         .d_in             (chain[n]),
         .d_out            (chain[n+1])
      );
   end

   always_comb begin
      rnd = chain[MAX_OCTAVES].sum + SW'(32768);
      res = rnd >>> 16;
      priority if (res > SW'(2097151)) begin
         sample_in = FW'(2097151);
      end else if (res < -SW'(2097152)) begin
         sample_in = FW'(-2097152);
      end else begin
         sample_in = res[FW-1:0];
      end
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      if (zero_done) begin
         sample_in    = '0;
         out_valid_in = 1'b1;
      end else if (chain[MAX_OCTAVES].valid) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (zero_done || chain[MAX_OCTAVES].valid) begin
         sample_ff <= sample_in;
      end
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.sample = sample_ff;

endmodule
`default_nettype wire
